>>> hdl/ffba_pkg.sv
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared constants, types and the microcode store of the first-fit allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int TOTAL_WORDS = 4096;
  localparam int TABLE_WORDS = 256;

  localparam int AW     = $clog2(TOTAL_WORDS);  // word address width
  localparam int SW     = $clog2(TABLE_WORDS);  // slot index width
  localparam int SIZE_W = 12;                   // size_words field width
  localparam int MARK_W = 13;                   // word mark width
  localparam int PC_W   = 5;                    // microcode step counter width

  localparam logic [MARK_W-1:0] BUSY_MARK = {MARK_W{1'b1}};
  localparam logic              CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SLOT  = 2'd1,
    ST_NO_RUN   = 2'd2,
    ST_NOT_USED = 2'd3
  } status_e;

  // datapath operations, one per control word
  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLR_WR,
    OP_TAKE,
    OP_SLOT_INC,
    OP_RES_NOSLOT,
    OP_SCAN_INIT,
    OP_SCAN_STEP,
    OP_RES_NORUN,
    OP_MARK_HEAD,
    OP_MARK_TAIL,
    OP_COMMIT_ALLOC,
    OP_FREE_RDBASE,
    OP_FREE_RDMARK,
    OP_FREE_LEN,
    OP_FREE_CLR,
    OP_COMMIT_FREE,
    OP_RES_NOTUSED,
    OP_PUSH
  } op_e;

  // jump conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_PTR_MORE,
    C_NO_INPUT,
    C_IS_FREE,
    C_SLOT_FREE,
    C_SLOT_MORE,
    C_SIZE_ZERO,
    C_SCAN_GO,
    C_FOUND,
    C_CNT_MORE,
    C_SLOT_UNUSED,
    C_CLR_MORE,
    C_OUT_BUSY
  } cond_e;

  typedef struct packed {
    logic no_input;
    logic is_free;
    logic slot_free;
    logic slot_more;
    logic size_zero;
    logic scan_go;
    logic found;
    logic cnt_more;
    logic slot_unused;
    logic clr_more;
    logic ptr_more;
  } flags_t;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [PC_W-1:0]  tgt;
  } uword_t;

  // step addresses
  localparam logic [PC_W-1:0] STEP_CLR       = 5'd0;
  localparam logic [PC_W-1:0] STEP_IDLE      = 5'd1;
  localparam logic [PC_W-1:0] STEP_DISP      = 5'd2;
  localparam logic [PC_W-1:0] STEP_SLOT_CHK  = 5'd3;
  localparam logic [PC_W-1:0] STEP_SLOT_NXT  = 5'd4;
  localparam logic [PC_W-1:0] STEP_FAIL_SLOT = 5'd5;
  localparam logic [PC_W-1:0] STEP_SIZE_CHK  = 5'd6;
  localparam logic [PC_W-1:0] STEP_SCAN      = 5'd7;
  localparam logic [PC_W-1:0] STEP_FOUND_CHK = 5'd8;
  localparam logic [PC_W-1:0] STEP_FAIL_RUN  = 5'd9;
  localparam logic [PC_W-1:0] STEP_HEAD      = 5'd10;
  localparam logic [PC_W-1:0] STEP_TAIL      = 5'd11;
  localparam logic [PC_W-1:0] STEP_ALLOC_OK  = 5'd12;
  localparam logic [PC_W-1:0] STEP_FREE_CHK  = 5'd13;
  localparam logic [PC_W-1:0] STEP_FREE_RDMK = 5'd14;
  localparam logic [PC_W-1:0] STEP_FREE_LEN  = 5'd15;
  localparam logic [PC_W-1:0] STEP_FREE_CLR  = 5'd16;
  localparam logic [PC_W-1:0] STEP_FREE_OK   = 5'd17;
  localparam logic [PC_W-1:0] STEP_FAIL_FREE = 5'd18;
  localparam logic [PC_W-1:0] STEP_OUT       = 5'd19;
  localparam logic [PC_W-1:0] STEP_RET       = 5'd20;

  // Microprogram. A taken condition jumps to tgt, otherwise fall through.
  function automatic uword_t ucode_rom(input logic [PC_W-1:0] pc);
    uword_t w;
    unique case (pc)
      STEP_CLR:       w = '{OP_CLR_WR,       C_PTR_MORE,    STEP_CLR};
      STEP_IDLE:      w = '{OP_TAKE,         C_NO_INPUT,    STEP_IDLE};
      STEP_DISP:      w = '{OP_NONE,         C_IS_FREE,     STEP_FREE_CHK};
      STEP_SLOT_CHK:  w = '{OP_NONE,         C_SLOT_FREE,   STEP_SIZE_CHK};
      STEP_SLOT_NXT:  w = '{OP_SLOT_INC,     C_SLOT_MORE,   STEP_SLOT_CHK};
      STEP_FAIL_SLOT: w = '{OP_RES_NOSLOT,   C_ALWAYS,      STEP_OUT};
      STEP_SIZE_CHK:  w = '{OP_SCAN_INIT,    C_SIZE_ZERO,   STEP_FAIL_RUN};
      STEP_SCAN:      w = '{OP_SCAN_STEP,    C_SCAN_GO,     STEP_SCAN};
      STEP_FOUND_CHK: w = '{OP_NONE,         C_FOUND,       STEP_HEAD};
      STEP_FAIL_RUN:  w = '{OP_RES_NORUN,    C_ALWAYS,      STEP_OUT};
      STEP_HEAD:      w = '{OP_MARK_HEAD,    C_NEVER,       STEP_TAIL};
      STEP_TAIL:      w = '{OP_MARK_TAIL,    C_CNT_MORE,    STEP_TAIL};
      STEP_ALLOC_OK:  w = '{OP_COMMIT_ALLOC, C_ALWAYS,      STEP_OUT};
      STEP_FREE_CHK:  w = '{OP_FREE_RDBASE,  C_SLOT_UNUSED, STEP_FAIL_FREE};
      STEP_FREE_RDMK: w = '{OP_FREE_RDMARK,  C_NEVER,       STEP_FREE_LEN};
      STEP_FREE_LEN:  w = '{OP_FREE_LEN,     C_NEVER,       STEP_FREE_CLR};
      STEP_FREE_CLR:  w = '{OP_FREE_CLR,     C_CLR_MORE,    STEP_FREE_CLR};
      STEP_FREE_OK:   w = '{OP_COMMIT_FREE,  C_ALWAYS,      STEP_OUT};
      STEP_FAIL_FREE: w = '{OP_RES_NOTUSED,  C_NEVER,       STEP_OUT};
      STEP_OUT:       w = '{OP_PUSH,         C_OUT_BUSY,    STEP_OUT};
      STEP_RET:       w = '{OP_NONE,         C_ALWAYS,      STEP_IDLE};
      default:        w = '{OP_NONE,         C_ALWAYS,      STEP_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> hdl/first_fit_block_allocator_core.sv
// ----------------------------------------------------------------------------
// first_fit_block_allocator_core
// Word-granular first-fit allocator with a descriptor slot table.
// ----------------------------------------------------------------------------
//  channel | handshake              | word
//  --------+------------------------+-------------------------------------
//  in      | in_valid_i / in_stall_o | cmd_i, size_words_i, slot_in_i
//  out     | out_valid_o/out_stall_i | status_o, slot_out_o, base_word_o
//
//  After reset the word mark memory and the slot-in-use table are cleared,
//  one address a cycle through all TOTAL_WORDS (4096) addresses, with
//  in_stall_o high. One word at a time. Allocate: slots are checked in
//  order up to the first free one, then mark words are scanned from
//  TABLE_WORDS up to the end of the fitting run (up to word TOTAL_WORDS-2
//  when none fits), then size_words mark words are written.
//  Free: the slot's base and head mark are read, then the block's mark
//  words are cleared; the result is pushed before the next word is taken.
//  A finished result sits in the output register; the next
//  word is taken while it waits, and the sequencer holds at its output step
//  only if the previous result has not been taken.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_core import ffba_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        cmd_i,
  input  logic [11:0] size_words_i,
  input  logic [7:0]  slot_in_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  status_o,
  output logic [7:0]  slot_out_o,
  output logic [11:0] base_word_o
);

  op_e           op;
  flags_t        flags;
  status_e       res_status;
  logic [SW-1:0] res_slot;
  logic [AW-1:0] res_base;

  logic          out_valid_q;
  status_e       out_status_q;
  logic [SW-1:0] out_slot_q;
  logic [AW-1:0] out_base_q;
  logic          out_busy;
  logic          push;

  ffba_seq u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .flags_i    (flags),
    .out_busy_i (out_busy),
    .op_o       (op)
  );

  ffba_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .op_i         (op),
    .in_valid_i   (in_valid_i),
    .cmd_i        (cmd_i),
    .size_words_i (size_words_i),
    .slot_in_i    (slot_in_i),
    .flags_o      (flags),
    .res_status_o (res_status),
    .res_slot_o   (res_slot),
    .res_base_o   (res_base)
  );

  // input is open only at the idle step of the microprogram
  assign in_stall_o = (op != OP_TAKE);

  // output register: free when empty or being drained this cycle
  assign out_busy = out_valid_q && out_stall_i;
  assign push     = (op == OP_PUSH) && !out_busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (push) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      out_status_q <= res_status;
      out_slot_q   <= res_slot;
      out_base_q   <= res_base;
    end
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign slot_out_o  = out_slot_q;
  assign base_word_o = out_base_q;

endmodule

>>> hdl/ffba_seq.sv
// ----------------------------------------------------------------------------
// ffba_seq
// Microcode sequencer: step counter, control store and branch selection.
// ----------------------------------------------------------------------------
module ffba_seq import ffba_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  flags_t flags_i,
  input  logic   out_busy_i,
  output op_e    op_o
);

  logic [PC_W-1:0] pc_q, pc_d;
  uword_t          uw;
  logic            take;

  assign uw   = ucode_rom(pc_q);
  assign op_o = uw.op;

  always_comb begin
    unique case (uw.cond)
      C_NEVER:       take = 1'b0;
      C_ALWAYS:      take = 1'b1;
      C_PTR_MORE:    take = flags_i.ptr_more;
      C_NO_INPUT:    take = flags_i.no_input;
      C_IS_FREE:     take = flags_i.is_free;
      C_SLOT_FREE:   take = flags_i.slot_free;
      C_SLOT_MORE:   take = flags_i.slot_more;
      C_SIZE_ZERO:   take = flags_i.size_zero;
      C_SCAN_GO:     take = flags_i.scan_go;
      C_FOUND:       take = flags_i.found;
      C_CNT_MORE:    take = flags_i.cnt_more;
      C_SLOT_UNUSED: take = flags_i.slot_unused;
      C_CLR_MORE:    take = flags_i.clr_more;
      C_OUT_BUSY:    take = out_busy_i;
      default:       take = 1'b0;
    endcase
  end

  assign pc_d = take ? uw.tgt : pc_q + PC_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= STEP_CLR;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

>>> hdl/ffba_dp.sv
// ----------------------------------------------------------------------------
// ffba_dp
// Allocator datapath: slot table, word mark memory, scan counters, result.
// ----------------------------------------------------------------------------
module ffba_dp import ffba_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  op_e               op_i,
  input  logic              in_valid_i,
  input  logic              cmd_i,
  input  logic [SIZE_W-1:0] size_words_i,
  input  logic [SW-1:0]     slot_in_i,
  output flags_t            flags_o,
  output status_e           res_status_o,
  output logic [SW-1:0]     res_slot_o,
  output logic [AW-1:0]     res_base_o
);

  // memories
  logic [MARK_W-1:0] mark_mem  [TOTAL_WORDS];
  logic [AW-1:0]     sbase_mem [TABLE_WORDS];
  logic              used_mem  [TABLE_WORDS];

  // control counters
  logic [AW:0]       ptr_q;     // extra bit flags the end of memory
  logic [SW-1:0]     slot_q;
  logic [AW-1:0]     i_q;
  logic [AW-1:0]     run_q;
  logic [MARK_W-1:0] cnt_q;
  logic              found_q;

  // payload
  logic              cmd_q;
  logic [SIZE_W-1:0] size_q;
  logic [SW-1:0]     slot_in_q;
  logic [AW-1:0]     base_q;
  logic [MARK_W-1:0] mark_q;
  logic [AW-1:0]     sbase_q;
  logic              used_q;
  status_e           res_status_q;
  logic [SW-1:0]     res_slot_q;
  logic [AW-1:0]     res_base_q;

  logic              mark_we;
  logic [AW-1:0]     mark_waddr;
  logic [MARK_W-1:0] mark_wdata;
  logic [AW-1:0]     mark_raddr;

  logic              used_we;
  logic [SW-1:0]     used_waddr;
  logic              used_wdata;
  logic [SW-1:0]     used_raddr;

  logic [AW-1:0]     run_nxt;
  logic              scan_hit;
  logic              cnt_more;
  logic              clr_more;
  logic              accept;

  assign accept   = (op_i == OP_TAKE) && in_valid_i;
  assign run_nxt  = (mark_q == '0) ? run_q + AW'(1) : '0;
  assign scan_hit = (run_nxt == AW'(size_q));
  assign cnt_more = (cnt_q != '0);
  assign clr_more = cnt_more && !ptr_q[AW];

  always_comb begin
    flags_o.no_input    = !in_valid_i;
    flags_o.is_free     = (cmd_q == CMD_FREE);
    flags_o.slot_free   = !used_q;
    flags_o.slot_more   = (slot_q != SW'(TABLE_WORDS - 1));
    flags_o.size_zero   = (size_q == '0);
    flags_o.scan_go     = !scan_hit && (i_q != AW'(TOTAL_WORDS - 2));
    flags_o.found       = found_q;
    flags_o.cnt_more    = cnt_more;
    flags_o.slot_unused = !used_q;
    flags_o.clr_more    = clr_more;
    flags_o.ptr_more    = (ptr_q[AW-1:0] != '1);
  end

  // mark memory port control
  always_comb begin
    mark_we    = 1'b0;
    mark_waddr = ptr_q[AW-1:0];
    mark_wdata = '0;
    mark_raddr = i_q + AW'(1);
    unique case (op_i)
      OP_CLR_WR:      mark_we = 1'b1;
      OP_SCAN_INIT:   mark_raddr = AW'(TABLE_WORDS);
      OP_MARK_HEAD: begin
        mark_we    = 1'b1;
        mark_waddr = base_q;
        mark_wdata = MARK_W'(size_q);
      end
      OP_MARK_TAIL: begin
        mark_we    = cnt_more;
        mark_wdata = BUSY_MARK;
      end
      OP_FREE_RDMARK: mark_raddr = sbase_q;
      OP_FREE_CLR:    mark_we = clr_more;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[mark_waddr] <= mark_wdata;
    end
    mark_q <= mark_mem[mark_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_COMMIT_ALLOC) begin
      sbase_mem[slot_q] <= base_q;
    end
    sbase_q <= sbase_mem[slot_in_q];
  end

  // slot table port control; the step ahead of a slot check reads its entry
  always_comb begin
    used_we    = 1'b0;
    used_waddr = slot_q;
    used_wdata = 1'b0;
    used_raddr = (cmd_q == CMD_FREE) ? slot_in_q : slot_q;
    unique case (op_i)
      OP_CLR_WR: begin
        used_we    = 1'b1;
        used_waddr = ptr_q[SW-1:0];
      end
      OP_SLOT_INC:     used_raddr = slot_q + SW'(1);
      OP_COMMIT_ALLOC: begin
        used_we    = 1'b1;
        used_wdata = 1'b1;
      end
      OP_COMMIT_FREE: begin
        used_we    = 1'b1;
        used_waddr = slot_in_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (used_we) begin
      used_mem[used_waddr] <= used_wdata;
    end
    used_q <= used_mem[used_raddr];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q       <= '0;
      slot_q      <= '0;
      i_q         <= '0;
      run_q       <= '0;
      cnt_q       <= '0;
      found_q     <= 1'b0;
    end else begin
      unique case (op_i)
        OP_CLR_WR:   ptr_q <= ptr_q + (AW+1)'(1);
        OP_TAKE: begin
          if (accept) begin
            slot_q <= '0;
          end
        end
        OP_SLOT_INC: slot_q <= slot_q + SW'(1);
        OP_SCAN_INIT: begin
          i_q     <= AW'(TABLE_WORDS);
          run_q   <= '0;
          found_q <= 1'b0;
        end
        OP_SCAN_STEP: begin
          run_q <= run_nxt;
          i_q   <= i_q + AW'(1);
          if (scan_hit) begin
            found_q <= 1'b1;
          end
        end
        OP_MARK_HEAD: begin
          ptr_q <= {1'b0, base_q} + (AW+1)'(1);
          cnt_q <= MARK_W'(size_q) - MARK_W'(1);
        end
        OP_MARK_TAIL: begin
          if (cnt_more) begin
            ptr_q <= ptr_q + (AW+1)'(1);
            cnt_q <= cnt_q - MARK_W'(1);
          end
        end
        OP_FREE_LEN: begin
          ptr_q <= {1'b0, base_q};
          cnt_q <= (mark_q == BUSY_MARK) ? MARK_W'(1) : mark_q;
        end
        OP_FREE_CLR: begin
          if (clr_more) begin
            ptr_q <= ptr_q + (AW+1)'(1);
            cnt_q <= cnt_q - MARK_W'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // payload and result
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q     <= cmd_i;
      size_q    <= size_words_i;
      slot_in_q <= slot_in_i;
    end
    if (op_i == OP_SCAN_STEP && scan_hit) begin
      base_q <= i_q + AW'(1) - AW'(size_q);
    end
    if (op_i == OP_FREE_RDMARK) begin
      base_q <= sbase_q;
    end
    unique case (op_i)
      OP_RES_NOSLOT: begin
        res_status_q <= ST_NO_SLOT;
        res_slot_q   <= '0;
        res_base_q   <= '0;
      end
      OP_RES_NORUN: begin
        res_status_q <= ST_NO_RUN;
        res_slot_q   <= '0;
        res_base_q   <= '0;
      end
      OP_RES_NOTUSED: begin
        res_status_q <= ST_NOT_USED;
        res_slot_q   <= '0;
        res_base_q   <= '0;
      end
      OP_COMMIT_ALLOC: begin
        res_status_q <= ST_OK;
        res_slot_q   <= slot_q;
        res_base_q   <= base_q;
      end
      OP_COMMIT_FREE: begin
        res_status_q <= ST_OK;
        res_slot_q   <= '0;
        res_base_q   <= base_q;
      end
      default: ;
    endcase
  end

  assign res_status_o = res_status_q;
  assign res_slot_o   = res_slot_q;
  assign res_base_o   = res_base_q;

endmodule
